// ===== sv/iir_direct_form2_fixed_unit_defines.svh =====
// assertion macros for the iir direct form ii unit
// included by the top level, no other dependencies
`ifndef IIR_DIRECT_FORM2_FIXED_UNIT_DEFINES_SVH
`define IIR_DIRECT_FORM2_FIXED_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IIRDF2_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("iir unit: same-cycle check failed");

// next-cycle implication, checked outside reset
`define IIRDF2_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("iir unit: next-cycle check failed");

`endif

// ===== sv/iirdf2_pkg.sv =====
// shared widths, register codes and helpers for the iir direct form ii unit
// no dependencies
`timescale 1ns / 1ps

package iirdf2_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int DATA_W     = 32;
  localparam int OUT_W      = 32;
  localparam int SHIFT_W    = 4;
  localparam int MAX_TAPS   = 4;
  localparam int DEF_TAPS   = 4;
  localparam int CIDX_W     = $clog2(MAX_TAPS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = COEF_W + DATA_W;
  // four products, or three products plus the scaled sample, with headroom
  localparam int ACC_W      = PROD_W + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_B0    = 3'd0,
    REG_COEF_B1    = 3'd1,
    REG_COEF_B2    = 3'd2,
    REG_COEF_B3    = 3'd3,
    REG_COEF_A1    = 3'd4,
    REG_COEF_A2    = 3'd5,
    REG_COEF_A3    = 3'd6,
    REG_FRAC_SHIFT = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic                     valid;
    logic                     sub;
    logic signed [COEF_W-1:0] coef;
    logic signed [DATA_W-1:0] data;
  } mac_op_t;

  // arithmetic right shift then wrap to the output width
  function automatic logic signed [OUT_W-1:0] scale_wrap(logic signed [ACC_W-1:0] v,
                                                         logic [SHIFT_W-1:0] s);
    logic signed [ACC_W-1:0] t;
    t = v >>> s;
    return t[OUT_W-1:0];
  endfunction

endpackage

// ===== sv/iirdf2_in_if.sv =====
// input sample channel of the iir direct form ii unit
// depends on iirdf2_pkg
`timescale 1ns / 1ps

interface iirdf2_in_if import iirdf2_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// ===== sv/iirdf2_out_if.sv =====
// output sample channel of the iir direct form ii unit
// depends on iirdf2_pkg
`timescale 1ns / 1ps

interface iirdf2_out_if import iirdf2_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== sv/iirdf2_cfg.sv =====
// coefficient and shift register file, written through a plain write port
// depends on iirdf2_pkg
`timescale 1ns / 1ps

module iirdf2_cfg import iirdf2_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata_i,
  output logic signed [COEF_W-1:0]     coef_b_o [MAX_TAPS],
  output logic signed [COEF_W-1:0]     coef_a_o [MAX_TAPS],
  output logic [SHIFT_W-1:0]           frac_shift_o
);

  logic signed [COEF_W-1:0] coef_b_q [MAX_TAPS];
  logic signed [COEF_W-1:0] coef_a_q [MAX_TAPS];
  logic [SHIFT_W-1:0]       frac_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        coef_b_q[i] <= '0;
        coef_a_q[i] <= '0;
      end
      frac_shift_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        REG_COEF_B0, REG_COEF_B1, REG_COEF_B2, REG_COEF_B3: begin
          coef_b_q[cfg_idx_i[CIDX_W-1:0]] <= cfg_wdata_i[COEF_W-1:0];
        end
        REG_COEF_A1:    coef_a_q[1] <= cfg_wdata_i[COEF_W-1:0];
        REG_COEF_A2:    coef_a_q[2] <= cfg_wdata_i[COEF_W-1:0];
        REG_COEF_A3:    coef_a_q[3] <= cfg_wdata_i[COEF_W-1:0];
        REG_FRAC_SHIFT: frac_shift_q <= cfg_wdata_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // a[0] is unity and never written, it stays at zero
  assign coef_b_o     = coef_b_q;
  assign coef_a_o     = coef_a_q;
  assign frac_shift_o = frac_shift_q;

endmodule

// ===== sv/iirdf2_mac.sv =====
// shared multiply-accumulate unit: registered product, then accumulate or subtract
// depends on iirdf2_pkg
`timescale 1ns / 1ps

module iirdf2_mac import iirdf2_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_op_t                 op_i,
  input  logic                    load_i,
  input  logic signed [ACC_W-1:0] load_val_i,
  output logic signed [ACC_W-1:0] acc_o,
  output logic                    busy_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic                     prod_sub_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      prod_sub_q <= 1'b0;
    end else begin
      prod_vld_q <= op_i.valid;
      prod_sub_q <= op_i.sub;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.valid) begin
      prod_q <= op_i.coef * op_i.data;
    end
    acc_q <= acc_d;
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (load_i) begin
      acc_d = load_val_i;
    end else if (prod_vld_q) begin
      acc_d = prod_sub_q ? (acc_q - prod_ext) : (acc_q + prod_ext);
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_vld_q;

endmodule

// ===== sv/iir_direct_form2_fixed_unit.sv =====
// fixed-point direct form ii iir filter, one output sample for each input sample.
// every sample runs through one shared multiply-accumulate unit: first the feedback
// sum x*2^shift - a[1]w[1] - ... - a[TAPS-1]w[TAPS-1], shifted back to give the new
// delay value w0 (wrapped to 32 bits), then the feed-forward sum b[0]w0 + ... +
// b[TAPS-1]w[TAPS-1], shifted right and wrapped to 32 bits for the output. one
// sample occupies the unit from transfer to the next point of readiness, as the
// single multiplier takes one product a cycle and its two-stage pipeline is
// drained twice, once after each pass. the input is ready only while the sequencer
// is idle. the result sits in an output register, so a new sample is taken while
// the previous result still waits for transfer. coefficients and shift are
// written through the plain write port; the user must write them only while the
// unit is idle, the block itself does not enforce it. depends on iirdf2_pkg,
// the two channel interfaces, iirdf2_cfg, iirdf2_mac and the assertion macro header.
`timescale 1ns / 1ps
`include "iir_direct_form2_fixed_unit_defines.svh"

module iir_direct_form2_fixed_unit import iirdf2_pkg::*; #(
  parameter int TAPS = DEF_TAPS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  iirdf2_in_if.sink             in_chan,
  iirdf2_out_if.source          out_chan,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int KW = $clog2(TAPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB,
    ST_FB_DRAIN,
    ST_W0,
    ST_FF,
    ST_FF_DRAIN,
    ST_FIN
  } state_e;

  // sequencer and data registers
  state_e                   state_q, state_d;
  logic [KW-1:0]            k_q, k_d;
  logic signed [DATA_W-1:0] w0_q, w0_d;
  logic signed [DATA_W-1:0] dly_q [TAPS-1];
  logic signed [DATA_W-1:0] dly_d [TAPS-1];
  logic signed [OUT_W-1:0]  out_q, out_d;
  logic                     out_valid_q, out_valid_d;

  // configuration
  logic signed [COEF_W-1:0] coef_b [MAX_TAPS];
  logic signed [COEF_W-1:0] coef_a [MAX_TAPS];
  logic [SHIFT_W-1:0]       frac_shift;

  // shared unit hookup
  mac_op_t                  mac_op;
  logic                     mac_load;
  logic signed [ACC_W-1:0]  mac_load_val;
  logic signed [ACC_W-1:0]  mac_acc;
  logic                     mac_busy;

  logic                     in_xfer;
  logic                     fin_commit;
  logic signed [ACC_W-1:0]  x_scaled;
  logic signed [DATA_W-1:0] w_all [TAPS];
  logic [CIDX_W-1:0]        cidx;

  iirdf2_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .coef_b_o     (coef_b),
    .coef_a_o     (coef_a),
    .frac_shift_o (frac_shift)
  );

  iirdf2_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (mac_op),
    .load_i     (mac_load),
    .load_val_i (mac_load_val),
    .acc_o      (mac_acc),
    .busy_o     (mac_busy)
  );

  assign in_chan.ready = (state_q == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  // the last step waits only while an older result is still unclaimed
  assign fin_commit    = (state_q == ST_FIN) && (!out_valid_q || out_chan.ready);

  // sample scaled up by the shift, seeds the feedback sum
  assign x_scaled = {{(ACC_W-SAMPLE_W){in_chan.sample_in[SAMPLE_W-1]}}, in_chan.sample_in}
                    <<< frac_shift;

  // tap k reads w0 for k = 0 and the delay line otherwise
  always_comb begin
    w_all[0] = w0_q;
    for (int i = 1; i < TAPS; i++) begin
      w_all[i] = dly_q[i-1];
    end
  end

  assign cidx = CIDX_W'(k_q);

  always_comb begin
    mac_op.valid = (state_q == ST_FB) || (state_q == ST_FF);
    mac_op.sub   = (state_q == ST_FB);
    mac_op.coef  = (state_q == ST_FB) ? coef_a[cidx] : coef_b[cidx];
    mac_op.data  = w_all[k_q];
  end

  assign mac_load     = in_xfer || (state_q == ST_W0);
  assign mac_load_val = in_xfer ? x_scaled : '0;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    w0_d        = w0_q;
    dly_d       = dly_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_chan.ready;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          k_d     = KW'(1);
          state_d = ST_FB;
        end
      end
      ST_FB: begin
        k_d = k_q + KW'(1);
        if (k_q == KW'(TAPS - 1)) begin
          // counter parks at zero so it never points past the last tap
          k_d     = '0;
          state_d = ST_FB_DRAIN;
        end
      end
      ST_FB_DRAIN: begin
        state_d = ST_W0;
      end
      ST_W0: begin
        // feedback sum is final here, accumulator is cleared for the forward pass
        w0_d    = scale_wrap(mac_acc, frac_shift);
        k_d     = '0;
        state_d = ST_FF;
      end
      ST_FF: begin
        k_d = k_q + KW'(1);
        if (k_q == KW'(TAPS - 1)) begin
          k_d     = '0;
          state_d = ST_FF_DRAIN;
        end
      end
      ST_FF_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_commit) begin
          out_d       = scale_wrap(mac_acc, frac_shift);
          out_valid_d = 1'b1;
          dly_d[0]    = w0_q;
          for (int i = 1; i < TAPS - 1; i++) begin
            dly_d[i] = dly_q[i-1];
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TAPS - 1; i++) begin
        dly_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      dly_q       <= dly_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    w0_q  <= w0_d;
    out_q <= out_d;
  end

  assign out_chan.valid      = out_valid_q;
  assign out_chan.sample_out = out_q;

  // no product may still be in flight when the accumulator is reloaded
  `IIRDF2_ASSERT_IMP(a_mac_drained_on_load, clk_i, rst_ni, mac_load, !mac_busy)
  // tap counter never walks past the last tap
  `IIRDF2_ASSERT_IMP(a_tap_in_range, clk_i, rst_ni, 1'b1, k_q <= KW'(TAPS - 1))
  // a finished sample always shows up as a pending result with the sequencer idle
  `IIRDF2_ASSERT_NEXT(a_fin_publishes, clk_i, rst_ni, fin_commit,
                      out_valid_q && (state_q == ST_IDLE))

endmodule
